// ===== sv/assert_macros.svh =====
// Assertion helpers for the buffer cache directory.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CHK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CHK_ASSERT(lbl, clk, rst_n, prop)
`define CHK_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/bbcd_pkg.sv =====
package bbcd_pkg;

  localparam int unsigned DEF_ENTRIES = 256;
  localparam int unsigned SECTOR_SHIFT = 9;

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_DONE    = 2'd2;
  localparam logic [1:0] OP_ERROR   = 2'd3;

  localparam logic [2:0] ST_HIT  = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_BUSY = 3'd2;
  localparam logic [2:0] ST_NONE = 3'd3;
  localparam logic [2:0] ST_BAD  = 3'd4;

  localparam int unsigned FL_BUSY  = 0;
  localparam int unsigned FL_VALID = 1;
  localparam int unsigned FL_DONE  = 2;
  localparam int unsigned FL_ERROR = 3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DECIDE,
    S_APPEND,
    S_RESP
  } state_e;

  // per-entry word: stored error, size in sectors, flags
  typedef struct packed {
    logic [7:0] err;
    logic [7:0] size;
    logic [3:0] flags;
  } ent_t;

  // tag word
  typedef struct packed {
    logic        present;
    logic [7:0]  dev;
    logic [31:0] blk;
  } tag_t;

endpackage

// ===== sv/bbcd_ram.sv =====
module bbcd_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/block_buffer_cache_directory_unit.sv =====
// Buffer cache directory: one item in flight at a time.
// A get walks the stored tags, reading one stored tag a cycle; a hit stops the walk, a miss
// walks them all. No new item is accepted until the last result is in the output register.
// Reset: asynchronous, active low; then a clearing pass over every entry initialises
// tags, flags and free-list links before the first item.
`include "assert_macros.svh"

module block_buffer_cache_directory_unit #(
  parameter int unsigned ENTRIES = bbcd_pkg::DEF_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  device_i,
  input  logic [31:0] block_number_i,
  input  logic [16:0] block_size_i,
  input  logic [7:0]  buffer_index_i,
  input  logic [7:0]  error_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  granted_index_o,
  output logic        data_valid_o,
  output logic [7:0]  sector_count_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW = AW + 1;            // link width, holds the null link
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
  localparam int unsigned TW = $bits(bbcd_pkg::tag_t);
  localparam int unsigned EW = $bits(bbcd_pkg::ent_t);

  bbcd_pkg::state_e state_q, state_d;

  // latched item
  logic [1:0]  op_q, op_d;
  logic [7:0]  dev_q, dev_d;
  logic [31:0] blk_q, blk_d;
  logic [7:0]  secs_q, secs_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  err_q, err_d;

  // walk and entry under work
  logic [LW-1:0] sc_q, sc_d;
  logic          rvld_q, rvld_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic [AW-1:0] m_q, m_d;
  logic          miss_q, miss_d;
  logic [AW-1:0] clr_q, clr_d;

  // free list ends
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] tail_q, tail_d;

  // pending result and output register
  logic [2:0] rst_q, rst_d;
  logic [7:0] ridx8_q, ridx8_d;
  logic       rval_q, rval_d;
  logic [7:0] rsec_q, rsec_d;
  logic       ov_q, ov_d;
  logic [2:0] ost_q, ost_d;
  logic [7:0] oidx_q, oidx_d;
  logic       oval_q, oval_d;
  logic [7:0] osec_q, osec_d;

  // memory ports
  logic          tag_we, ent_we, nxt_we, prv_we;
  logic [AW-1:0] tag_wa, ent_wa, nxt_wa, prv_wa;
  logic [AW-1:0] tag_ra, lnk_ra;
  bbcd_pkg::tag_t tag_wd, tag_rd;
  bbcd_pkg::ent_t ent_wd, ent_rd;
  logic [LW-1:0]  nxt_wd, prv_wd, nxt_rd, prv_rd;
  logic [TW-1:0]  tag_rd_raw;
  logic [EW-1:0]  ent_rd_raw;

  assign tag_rd = bbcd_pkg::tag_t'(tag_rd_raw);
  assign ent_rd = bbcd_pkg::ent_t'(ent_rd_raw);

  bbcd_ram #(.DEPTH(ENTRIES), .WIDTH(TW), .AW(AW)) u_tag (
    .clk_i, .we_i(tag_we), .waddr_i(tag_wa), .wdata_i(TW'(tag_wd)),
    .raddr_i(tag_ra), .rdata_o(tag_rd_raw)
  );
  bbcd_ram #(.DEPTH(ENTRIES), .WIDTH(EW), .AW(AW)) u_ent (
    .clk_i, .we_i(ent_we), .waddr_i(ent_wa), .wdata_i(EW'(ent_wd)),
    .raddr_i(lnk_ra), .rdata_o(ent_rd_raw)
  );
  bbcd_ram #(.DEPTH(ENTRIES), .WIDTH(LW), .AW(AW)) u_nxt (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(lnk_ra), .rdata_o(nxt_rd)
  );
  bbcd_ram #(.DEPTH(ENTRIES), .WIDTH(LW), .AW(AW)) u_prv (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .raddr_i(lnk_ra), .rdata_o(prv_rd)
  );

  // size check: 512..65536 in whole sectors
  logic       size_ok;
  logic [7:0] secs_in;
  assign size_ok = (block_size_i[bbcd_pkg::SECTOR_SHIFT-1:0] == '0) &&
                   (block_size_i != '0) && (block_size_i <= 17'd65536);
  assign secs_in = block_size_i[16:bbcd_pkg::SECTOR_SHIFT];

  logic idx_ok;
  assign idx_ok = 32'(buffer_index_i) < ENTRIES;

  logic tag_hit;
  assign tag_hit = tag_rd.present && (tag_rd.dev == dev_q) && (tag_rd.blk == blk_q);

  assign in_ready_o = (state_q == bbcd_pkg::S_IDLE);

  always_comb begin
    logic [3:0] f;
    f       = ent_rd.flags;
    state_d = state_q;
    op_d = op_q; dev_d = dev_q; blk_d = blk_q; secs_d = secs_q;
    idx_d = idx_q; err_d = err_q;
    sc_d = sc_q; rvld_d = 1'b0; ridx_d = ridx_q; m_d = m_q; miss_d = miss_q;
    clr_d = clr_q; head_d = head_q; tail_d = tail_q;
    rst_d = rst_q; ridx8_d = ridx8_q; rval_d = rval_q; rsec_d = rsec_q;
    ov_d = ov_q; ost_d = ost_q; oidx_d = oidx_q; oval_d = oval_q; osec_d = osec_q;
    tag_we = 1'b0; ent_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0;
    tag_wa = m_q; ent_wa = m_q; nxt_wa = m_q; prv_wa = m_q;
    tag_wd = '{present: 1'b1, dev: dev_q, blk: blk_q};
    ent_wd = ent_rd;
    nxt_wd = NIL; prv_wd = NIL;
    tag_ra = sc_q[AW-1:0];
    lnk_ra = m_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      bbcd_pkg::S_CLEAR: begin
        tag_we = 1'b1; ent_we = 1'b1; nxt_we = 1'b1; prv_we = 1'b1;
        tag_wa = clr_q; ent_wa = clr_q; nxt_wa = clr_q; prv_wa = clr_q;
        tag_wd = '0;
        ent_wd = '0;
        nxt_wd = LW'(clr_q) + LW'(1);
        prv_wd = (clr_q == '0) ? NIL : LW'(clr_q) - LW'(1);
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST) begin
          state_d = bbcd_pkg::S_IDLE;
        end
      end

      bbcd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i; dev_d = device_i; blk_d = block_number_i;
          secs_d = secs_in; idx_d = buffer_index_i; err_d = error_code_i;
          if (operation_i == bbcd_pkg::OP_GET) begin
            if (!size_ok) begin
              rst_d = bbcd_pkg::ST_BAD; ridx8_d = '0; rval_d = 1'b0; rsec_d = '0;
              state_d = bbcd_pkg::S_RESP;
            end else begin
              sc_d = '0;
              state_d = bbcd_pkg::S_SCAN;
            end
          end else if (!idx_ok) begin
            rst_d = bbcd_pkg::ST_BAD; ridx8_d = buffer_index_i;
            rval_d = 1'b0; rsec_d = '0;
            state_d = bbcd_pkg::S_RESP;
          end else begin
            m_d = AW'(buffer_index_i);
            miss_d = 1'b0;
            state_d = bbcd_pkg::S_READ;
          end
        end
      end

      // one tag read issued a cycle, compared the next
      bbcd_pkg::S_SCAN: begin
        if (sc_q < NIL) begin
          sc_d = sc_q + LW'(1);
          rvld_d = 1'b1;
          ridx_d = sc_q[AW-1:0];
        end
        if (rvld_q && tag_hit) begin
          m_d = ridx_q; miss_d = 1'b0;
          state_d = bbcd_pkg::S_READ;
        end else if (rvld_q && ridx_q == LAST) begin
          if (head_q == NIL) begin
            rst_d = bbcd_pkg::ST_NONE; ridx8_d = '0; rval_d = 1'b0; rsec_d = '0;
            state_d = bbcd_pkg::S_RESP;
          end else begin
            m_d = head_q[AW-1:0]; miss_d = 1'b1;
            state_d = bbcd_pkg::S_READ;
          end
        end
      end

      bbcd_pkg::S_READ: begin
        state_d = bbcd_pkg::S_DECIDE;
      end

      bbcd_pkg::S_DECIDE: begin
        state_d = bbcd_pkg::S_RESP;
        if (op_q == bbcd_pkg::OP_GET) begin
          if (miss_q) begin
            // take the free-list head and retag it
            tag_we = 1'b1;
            ent_we = 1'b1;
            ent_wd.size = secs_q;
            ent_wd.flags = '0;
            ent_wd.flags[bbcd_pkg::FL_BUSY] = 1'b1;
            head_d = nxt_rd;
            if (nxt_rd == NIL) begin
              tail_d = NIL;
            end else begin
              prv_we = 1'b1; prv_wa = nxt_rd[AW-1:0]; prv_wd = NIL;
            end
            rst_d = bbcd_pkg::ST_MISS; ridx8_d = 8'(m_q); rval_d = 1'b0; rsec_d = secs_q;
          end else if (f[bbcd_pkg::FL_BUSY]) begin
            rst_d = bbcd_pkg::ST_BUSY; ridx8_d = 8'(m_q);
            rval_d = f[bbcd_pkg::FL_VALID]; rsec_d = ent_rd.size;
          end else begin
            if (secs_q < ent_rd.size) f[bbcd_pkg::FL_VALID] = 1'b0;
            f[bbcd_pkg::FL_BUSY] = 1'b1;
            f[bbcd_pkg::FL_DONE] = 1'b0;
            f[bbcd_pkg::FL_ERROR] = 1'b0;
            ent_we = 1'b1; ent_wd.flags = f; ent_wd.size = secs_q;
            // unlink from the free list
            if (prv_rd == NIL) begin
              head_d = nxt_rd;
            end else begin
              nxt_we = 1'b1; nxt_wa = prv_rd[AW-1:0]; nxt_wd = nxt_rd;
            end
            if (nxt_rd == NIL) begin
              tail_d = prv_rd;
            end else begin
              prv_we = 1'b1; prv_wa = nxt_rd[AW-1:0]; prv_wd = prv_rd;
            end
            rst_d = bbcd_pkg::ST_HIT; ridx8_d = 8'(m_q);
            rval_d = f[bbcd_pkg::FL_VALID]; rsec_d = secs_q;
          end
        end else if (!f[bbcd_pkg::FL_BUSY]) begin
          rst_d = bbcd_pkg::ST_BAD; ridx8_d = idx_q; rval_d = 1'b0; rsec_d = '0;
        end else begin
          unique case (op_q)
            bbcd_pkg::OP_RELEASE: begin
              f[bbcd_pkg::FL_BUSY] = 1'b0;
              f[bbcd_pkg::FL_DONE] = 1'b0;
              prv_we = 1'b1; prv_wd = tail_q;
              nxt_we = 1'b1; nxt_wd = NIL;
              state_d = bbcd_pkg::S_APPEND;
            end
            bbcd_pkg::OP_DONE: begin
              f[bbcd_pkg::FL_DONE] = 1'b1;
              f[bbcd_pkg::FL_VALID] = 1'b1;
            end
            default: begin
              ent_wd.err = err_q;
              f[bbcd_pkg::FL_DONE] = 1'b1;
              f[bbcd_pkg::FL_ERROR] = 1'b1;
              f[bbcd_pkg::FL_VALID] = 1'b0;
            end
          endcase
          ent_we = 1'b1; ent_wd.flags = f;
          rst_d = bbcd_pkg::ST_HIT; ridx8_d = idx_q;
          rval_d = f[bbcd_pkg::FL_VALID]; rsec_d = ent_rd.size;
        end
      end

      // second half of append: link old tail forward
      bbcd_pkg::S_APPEND: begin
        if (tail_q == NIL) begin
          head_d = LW'(m_q);
        end else begin
          nxt_we = 1'b1; nxt_wa = tail_q[AW-1:0]; nxt_wd = LW'(m_q);
        end
        tail_d = LW'(m_q);
        state_d = bbcd_pkg::S_RESP;
      end

      bbcd_pkg::S_RESP: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          ost_d = rst_q; oidx_d = ridx8_q; oval_d = rval_q; osec_d = rsec_q;
          state_d = bbcd_pkg::S_IDLE;
        end
      end

      default: state_d = bbcd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbcd_pkg::S_CLEAR;
      clr_q   <= '0;
      rvld_q  <= 1'b0;
      sc_q    <= '0;
      head_q  <= '0;
      tail_q  <= LW'(ENTRIES - 1);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rvld_q  <= rvld_d;
      sc_q    <= sc_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; dev_q <= dev_d; blk_q <= blk_d; secs_q <= secs_d;
    idx_q <= idx_d; err_q <= err_d;
    ridx_q <= ridx_d; m_q <= m_d; miss_q <= miss_d;
    rst_q <= rst_d; ridx8_q <= ridx8_d; rval_q <= rval_d; rsec_q <= rsec_d;
    ost_q <= ost_d; oidx_q <= oidx_d; oval_q <= oval_d; osec_q <= osec_d;
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign granted_index_o = oidx_q;
  assign data_valid_o    = oval_q;
  assign sector_count_o  = osec_q;

  `CHK_ASSERT(a_ends_in_range, clk_i, rst_ni, (head_q <= NIL) && (tail_q <= NIL))
  `CHK_ASSERT(a_list_empty_both, clk_i, rst_ni, (state_q == bbcd_pkg::S_IDLE) |-> ((head_q == NIL) == (tail_q == NIL)))
  `CHK_ASSERT(a_miss_not_valid, clk_i, rst_ni, (ov_q && ost_q == bbcd_pkg::ST_MISS) |-> !oval_q)
  `CHK_ASSERT(a_bad_no_sectors, clk_i, rst_ni, (ov_q && ost_q == bbcd_pkg::ST_BAD) |-> (osec_q == '0 && !oval_q))

endmodule
